>>> sv/terrain_geomorph_vertex_heights_unit_macros.svh
// Assertion helpers for the geomorph height unit.
`ifndef TERRAIN_GEOMORPH_VERTEX_HEIGHTS_UNIT_MACROS_SVH
`define TERRAIN_GEOMORPH_VERTEX_HEIGHTS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define TGVH_ASSERT_CLK(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define TGVH_ASSERT(lbl, prop, msg) `TGVH_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define TGVH_ASSERT_CLK(lbl, ck, rn, prop, msg)
`define TGVH_ASSERT(lbl, prop, msg)
`endif

`endif

>>> sv/tgvh_pkg.sv
package tgvh_pkg;

    localparam int LOD_DIM = 64;
    localparam int DEPTH   = LOD_DIM * LOD_DIM;
    localparam int COORD_W = (LOD_DIM > 1) ? $clog2(LOD_DIM) : 1;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam int POS_W     = 7;
    localparam int RES_W     = 7;
    localparam int H_W       = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [RES_W-1:0] RES_X_RESET     = 7'd127;
    localparam logic [RES_W-1:0] RES_Z_RESET     = 7'd127;
    localparam logic [H_W-1:0]   MORPH_FIX_RESET = 32'd459;

    localparam logic [CFG_IDX_W-1:0] CFG_RES_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_Z     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MORPH_FIX = 2'd2;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_VERTEX = 1'b1;

    // Decoded view of one request, produced by the address generator.
    typedef struct packed {
        logic in_grid;
        logic blend;
        logic oor;
    } tgvh_dec_t;

    // What travels alongside a vertex while its coarse reads are in flight.
    typedef struct packed {
        logic                  blend;
        logic                  oor;
        logic signed [H_W-1:0] fine;
    } tgvh_tag_t;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [POS_W-1:0] c);
        if (int'(c) > LOD_DIM - 1)
            return COORD_W'(LOD_DIM - 1);
        else
            return COORD_W'(c);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [COORD_W-1:0] cx,
                                                  input logic [COORD_W-1:0] cz);
        return ADDR_W'(int'(cz) * LOD_DIM + int'(cx));
    endfunction

endpackage

>>> sv/tgvh_if.sv
interface tgvh_req_if;
    import tgvh_pkg::*;
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_z;
    logic [H_W-1:0]   height_in;

    modport source (output valid, cmd, pos_x, pos_z, height_in, input ready);
    modport sink (input valid, cmd, pos_x, pos_z, height_in, output ready);
endinterface

interface tgvh_rsp_if;
    import tgvh_pkg::*;
    logic           valid;
    logic           ready;
    logic [H_W-1:0] fine_height;
    logic [H_W-1:0] morph_height;
    logic           out_of_range;

    modport source (output valid, fine_height, morph_height, out_of_range, input ready);
    modport sink (input valid, fine_height, morph_height, out_of_range, output ready);
endinterface

interface tgvh_cfg_if;
    import tgvh_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [H_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> sv/tgvh_ram.sv
module tgvh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

>>> sv/tgvh_addr.sv
module tgvh_addr (
    input  logic [tgvh_pkg::POS_W-1:0]  pos_x,
    input  logic [tgvh_pkg::POS_W-1:0]  pos_z,
    input  logic                        cmd,
    input  logic [tgvh_pkg::RES_W-1:0]  res_x,
    input  logic [tgvh_pkg::RES_W-1:0]  res_z,
    output logic [tgvh_pkg::ADDR_W-1:0] wr_addr,
    output logic [tgvh_pkg::ADDR_W-1:0] rd_addr_a,
    output logic [tgvh_pkg::ADDR_W-1:0] rd_addr_b,
    output tgvh_pkg::tgvh_dec_t         dec
);
    import tgvh_pkg::*;

    logic [POS_W-1:0] lx;
    logic [POS_W-1:0] lz;
    logic [POS_W-1:0] lx1;
    logic [POS_W-1:0] lz1;
    logic             ox;
    logic             oz;
    logic             diag;
    logic [POS_W-1:0] ax;
    logic [POS_W-1:0] az;
    logic [POS_W-1:0] bx;
    logic [POS_W-1:0] bz;

    always_comb
    begin
        lx   = {1'b0, pos_x[POS_W-1:1]};
        lz   = {1'b0, pos_z[POS_W-1:1]};
        lx1  = lx + POS_W'(1);
        lz1  = lz + POS_W'(1);
        ox   = pos_x[0];
        oz   = pos_z[0];
        diag = lx[0] ^ lz[0];

        ax = lx;
        az = lz;
        bx = lx;
        bz = lz;
        if (ox && oz)
        begin
            // The diagonal flips direction with the parity of the coarse cell.
            ax = diag ? lx1 : lx;
            bx = diag ? lx : lx1;
            bz = lz1;
        end
        else if (ox)
        begin
            bx = lx1;
        end
        else if (oz)
        begin
            bz = lz1;
        end

        rd_addr_a = addr_of(clamp_coord(ax), clamp_coord(az));
        rd_addr_b = addr_of(clamp_coord(bx), clamp_coord(bz));
        wr_addr   = addr_of(clamp_coord(pos_x), clamp_coord(pos_z));

        dec.in_grid = (cmd == CMD_LOAD) && (int'(pos_x) < LOD_DIM)
                      && (int'(pos_z) < LOD_DIM);
        dec.blend   = ox || oz;
        dec.oor     = (pos_x >= res_x) || (pos_z >= res_z);
    end

endmodule

>>> sv/tgvh_blend.sv
module tgvh_blend (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       vertex_acc,
    input  tgvh_pkg::tgvh_tag_t        tag_in,
    input  logic [tgvh_pkg::H_W-1:0]   coarse_a,
    input  logic [tgvh_pkg::H_W-1:0]   coarse_b,
    input  logic [tgvh_pkg::H_W-1:0]   morph_fix,
    output logic                       take,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [tgvh_pkg::H_W-1:0]   fine_height,
    output logic [tgvh_pkg::H_W-1:0]   morph_height,
    output logic                       out_of_range
);
    import tgvh_pkg::*;

    logic                  s1_v_reg;
    logic                  s1_v_next;
    tgvh_tag_t             s1_tag_reg;
    logic                  s2_v_reg;
    logic                  s2_v_next;
    tgvh_tag_t             s2_tag_reg;
    logic signed [H_W-1:0] s2_val_reg;
    logic signed [H_W-1:0] s2_val_next;
    logic                  out_v_reg;
    logic                  out_v_next;
    logic [H_W-1:0]        out_fine_reg;
    logic [H_W-1:0]        out_morph_reg;
    logic [H_W-1:0]        out_morph_next;
    logic                  out_oor_reg;

    logic                  out_free;
    logic                  s2_free;
    logic                  s1_free;
    logic signed [H_W:0]   pair_sum;
    logic signed [H_W+1:0] fixed_sum;

    always_comb
    begin
        out_free = !out_v_reg || out_ready;
        s2_free  = !s2_v_reg || out_free;
        s1_free  = !s1_v_reg || s2_free;
        take     = s1_free;

        s1_v_next  = s1_free ? vertex_acc : s1_v_reg;
        s2_v_next  = s2_free ? s1_v_reg : s2_v_reg;
        out_v_next = out_free ? s2_v_reg : out_v_reg;

        // Floor of the average: exact 33-bit sum, then drop the low bit.
        pair_sum    = $signed({coarse_a[H_W-1], coarse_a}) + $signed({coarse_b[H_W-1], coarse_b});
        s2_val_next = s1_tag_reg.blend ? pair_sum[H_W:1] : $signed(coarse_a);

        fixed_sum = $signed({{2{s2_val_reg[H_W-1]}}, s2_val_reg})
                    + $signed({{2{morph_fix[H_W-1]}}, morph_fix});

        if (s2_tag_reg.oor)
        begin
            out_morph_next = '0;
        end
        else if (!s2_tag_reg.blend)
        begin
            out_morph_next = s2_val_reg;
        end
        else if (fixed_sum[H_W+1:H_W-1] == 3'b000 || fixed_sum[H_W+1:H_W-1] == 3'b111)
        begin
            out_morph_next = fixed_sum[H_W-1:0];
        end
        else
        begin
            out_morph_next = fixed_sum[H_W+1] ? {1'b1, {(H_W-1){1'b0}}}
                                              : {1'b0, {(H_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s2_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_tag_reg <= tag_in;
        end
        if (s2_free)
        begin
            s2_tag_reg <= s1_tag_reg;
            s2_val_reg <= s2_val_next;
        end
        if (out_free)
        begin
            out_fine_reg  <= s2_tag_reg.fine;
            out_morph_reg <= out_morph_next;
            out_oor_reg   <= s2_tag_reg.oor;
        end
    end

    assign out_valid    = out_v_reg;
    assign fine_height  = out_fine_reg;
    assign morph_height = out_morph_reg;
    assign out_of_range = out_oor_reg;

endmodule

>>> sv/terrain_geomorph_vertex_heights_unit.sv
// A vertex request goes through the coarse read, average and output registers to rsp.
// Throughput: one transaction per cycle unless rsp.ready back-pressure stalls; the pair of
// coarse reads for a vertex comes from the dual-read port of the height memory at once.
// A coarse load gives no result.
// Reset clears the pipeline valid bits and restores the register defaults;
// the coarse height memory is not cleared and holds garbage until loaded.
`include "terrain_geomorph_vertex_heights_unit_macros.svh"

module terrain_geomorph_vertex_heights_unit (
    input logic clk,
    input logic rst_n,
    tgvh_req_if.sink   req,
    tgvh_rsp_if.source rsp,
    tgvh_cfg_if.sink   cfg
);
    import tgvh_pkg::*;

    logic [RES_W-1:0]  res_x_reg;
    logic [RES_W-1:0]  res_x_next;
    logic [RES_W-1:0]  res_z_reg;
    logic [RES_W-1:0]  res_z_next;
    logic [H_W-1:0]    fix_reg;
    logic [H_W-1:0]    fix_next;

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [H_W-1:0]    coarse_a;
    logic [H_W-1:0]    coarse_b;
    tgvh_dec_t         dec;
    tgvh_tag_t         tag;
    logic              take;
    logic              req_acc;
    logic              vertex_acc;
    logic              load_we;

    assign cfg.ready  = 1'b1;
    assign req.ready  = take;
    assign req_acc    = req.valid && take;
    assign vertex_acc = req_acc && (req.cmd == CMD_VERTEX);
    assign load_we    = req_acc && dec.in_grid;

    always_comb
    begin
        res_x_next = res_x_reg;
        res_z_next = res_z_reg;
        fix_next   = fix_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_RES_X:     res_x_next = cfg.data[RES_W-1:0];
                CFG_RES_Z:     res_z_next = cfg.data[RES_W-1:0];
                CFG_MORPH_FIX: fix_next   = cfg.data;
                default:       ;
            endcase
        end

        tag.blend = dec.blend;
        tag.oor   = dec.oor;
        tag.fine  = req.height_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_x_reg <= RES_X_RESET;
            res_z_reg <= RES_Z_RESET;
            fix_reg   <= MORPH_FIX_RESET;
        end
        else
        begin
            res_x_reg <= res_x_next;
            res_z_reg <= res_z_next;
            fix_reg   <= fix_next;
        end
    end

    tgvh_addr u_addr (
        .pos_x     (req.pos_x),
        .pos_z     (req.pos_z),
        .cmd       (req.cmd),
        .res_x     (res_x_reg),
        .res_z     (res_z_reg),
        .wr_addr   (wr_addr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .dec       (dec)
    );

    // A load writes at its accept edge, so a vertex accepted on the next edge
    // already reads the new entry.
    tgvh_ram #(
        .WIDTH (H_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (load_we),
        .waddr   (wr_addr),
        .wdata   (req.height_in),
        .re      (vertex_acc),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (coarse_a),
        .rdata_b (coarse_b)
    );

    tgvh_blend u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_acc   (vertex_acc),
        .tag_in       (tag),
        .coarse_a     (coarse_a),
        .coarse_b     (coarse_b),
        .morph_fix    (fix_reg),
        .take         (take),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .fine_height  (rsp.fine_height),
        .morph_height (rsp.morph_height),
        .out_of_range (rsp.out_of_range)
    );

    `TGVH_ASSERT(a_oor_zero, rsp.valid && rsp.out_of_range |-> rsp.morph_height == '0, "oor morph")
    `TGVH_ASSERT(a_stall_origin, !req.ready |-> rsp.valid && !rsp.ready, "stall without backpressure")
    `TGVH_ASSERT(a_load_no_vertex, req.valid && req.ready && req.cmd == CMD_LOAD |-> !vertex_acc, "load")

endmodule
